// File: hdl/csm_pkg.sv
// Shared constants, codes and types for the circular successor multiset.
// No dependencies.
`default_nettype none
package csm_pkg;

  localparam int VAL_W      = 10;   // item value / operand width
  localparam int MOD_W      = 11;   // modulus register width
  localparam int CNT_W      = 11;   // per-value count and total width
  localparam int STAT_W     = 2;
  localparam int WORD_IDX_W = 5;    // bit index inside one occupancy word
  localparam int WORD_W     = 1 << WORD_IDX_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2047);

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [7:0] {
    ST_CLR  = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_LD   = 8'b0000_0100,
    ST_RD1  = 8'b0000_1000,
    ST_RD2  = 8'b0001_0000,
    ST_CNT  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// File: hdl/csm_count_mem.sv
// Occurrence count memory: one write port, one registered read port.
// Depends on csm_pkg.
`default_nettype none
module csm_count_mem
  import csm_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [CNT_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [CNT_W-1:0] rdata
);

  logic [CNT_W-1:0] mem [0:(1<<AW)-1];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/csm_occ_mem.sv
// Occupancy bitmap memory, one word per 32 values, registered read.
// Depends on csm_pkg.
`default_nettype none
module csm_occ_mem
  import csm_pkg::*;
#(
  parameter int AW = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [0:(1<<AW)-1];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/csm_mod_unit.sv
// Bit-serial restoring remainder unit: computes dividend mod divisor.
// Depends on csm_pkg.
`default_nettype none
module csm_mod_unit
  import csm_pkg::*;
#(
  parameter int DW = 12,  // dividend width
  parameter int RW = 11   // divisor / remainder width
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RW-1:0] divisor,
  output logic               done,
  output logic      [RW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] sh_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  always_comb begin
    trial = {rem_r, sh_r[DW-1]};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sh_r   <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when it fits
        rem_r <= (trial >= {1'b0, div_r}) ? diff[RW-1:0] : trial[RW-1:0];
        sh_r  <= {sh_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: hdl/circular_successor_multiset_core.sv
// Circular successor multiset: top level with control sequencer and summary bits.
// Depends on csm_pkg, csm_count_mem, csm_occ_mem, csm_mod_unit.
//
// Input channel (in_valid/in_ready) carries one request: in_command selects a load
// (add one copy of in_item_value) or a query (operand a = in_item_value). A query
// finds the smallest stored value not below (M - a) mod M, wrapping to the smallest
// stored value, removes one copy and returns (a + value) mod M on the result channel
// (out_valid/out_ready) with out_status. Loads give no result. cfg_we/cfg_wdata write
// the modulus; write it only while the block is idle.
// Timing: one request at a time. A load passes through accept and count update.
// A valid query passes through a bitmap read, a second one when the target word holds
// no candidate, the count update, the remainder unit on the SW-bit sum (SW = 12 at
// MAX_VALUES = 1024) and the output load; in_ready returns in the same cycle that
// the result enters the output register. Range and empty errors skip the search
// and go straight to the output load.
// Reset: the block sweeps both memories, one count entry per cycle, with in_ready
// low; config writes are taken meanwhile.
// Stall: a finished result waits in the output register while the next request is
// accepted; a further result holds in its last state until out_ready frees the register.
`default_nettype none
module circular_successor_multiset_core
  import csm_pkg::*;
#(
  parameter int MAX_VALUES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [VAL_W-1:0]  in_item_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [VAL_W-1:0]  out_sum_result,
  output logic      [STAT_W-1:0] out_status,
  input  wire logic              cfg_we,
  input  wire logic [MOD_W-1:0]  cfg_wdata
);

  localparam int NWORDS = (MAX_VALUES + WORD_W - 1) / WORD_W;
  localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NWS    = 1 << WIW;
  localparam int PW     = WIW + WORD_IDX_W;       // value index width
  localparam int MW     = PW + 1;
  localparam int CW     = (MW > MOD_W) ? MW : MOD_W;
  localparam int SW     = CW + 1;                 // sum width

  // pick lowest set bit
  function automatic logic [WIW-1:0] low_w(input logic [NWS-1:0] x);
    logic [WIW-1:0] r;
    r = '0;
    for (int i = NWS - 1; i >= 0; i--) begin
      if (x[i]) r = WIW'(i);
    end
    return r;
  endfunction

  function automatic logic [WORD_IDX_W-1:0] low_b(input logic [WORD_W-1:0] x);
    logic [WORD_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (x[i]) r = WORD_IDX_W'(i);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [MOD_W-1:0]  modulus_r;
  logic [CNT_W-1:0]  total_r;
  logic [NWS-1:0]    summ_r;
  logic [PW-1:0]     clr_r;
  logic [CW-1:0]     v_r;
  logic [CW-1:0]     m_r;
  logic [PW-1:0]     t_r;
  logic [WIW-1:0]    w1_r;
  logic [PW-1:0]     pick_r;
  logic [WORD_W-1:0] word_r;
  logic [STAT_W-1:0] res_stat_r;
  logic [VAL_W-1:0]  res_sum_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_sum_r;
  logic [STAT_W-1:0] out_stat_r;

  // memory ports
  logic              cnt_we;
  logic [PW-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              occ_we;
  logic [WIW-1:0]    occ_waddr, occ_raddr;
  logic [WORD_W-1:0] occ_wdata, occ_rdata;

  logic              div_start, div_done;
  logic [CW-1:0]     div_rem;

  // request decode
  logic [CW-1:0]     mod_ext, m_eff, v_ext, t_c;
  logic [PW-1:0]     t_idx, v_idx;
  logic [WIW-1:0]    tw;
  logic [NWS-1:0]    above;
  logic [WIW-1:0]    w1_c;
  logic              accept;

  logic [WORD_W-1:0] masked;
  logic [PW-1:0]     pick_c;
  logic [WORD_W-1:0] word_clr, word_set;
  logic [PW-1:0]     vr_idx;
  logic              ld_ok;

  always_comb begin
    mod_ext = CW'(modulus_r);
    if (mod_ext == '0) begin
      m_eff = CW'(1);
    end else if (mod_ext > CW'(MAX_VALUES)) begin
      m_eff = CW'(MAX_VALUES);
    end else begin
      m_eff = mod_ext;
    end
    v_ext = CW'(in_item_value);
    t_c   = (v_ext == '0) ? '0 : (m_eff - v_ext);
    t_idx = PW'(t_c);
    v_idx = PW'(in_item_value);
    tw    = t_idx[PW-1:WORD_IDX_W];
    for (int i = 0; i < NWS; i++) begin
      above[i] = summ_r[i] && (WIW'(i) > tw);
    end
    // next occupied word past the target word, else wrap to the first one
    w1_c = (above != '0) ? low_w(above) : low_w(summ_r);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // word-level decisions
  always_comb begin
    masked = occ_rdata & ({WORD_W{1'b1}} << t_r[WORD_IDX_W-1:0]);
    if (state_r == ST_RD1) begin
      pick_c = {t_r[PW-1:WORD_IDX_W], low_b(masked)};
    end else begin
      pick_c = {w1_r, low_b(occ_rdata)};
    end
    word_clr = word_r & ~(WORD_W'(1) << pick_r[WORD_IDX_W-1:0]);
    vr_idx   = PW'(v_r);
    word_set = occ_rdata | (WORD_W'(1) << vr_idx[WORD_IDX_W-1:0]);
    ld_ok    = (v_r < m_r) && (total_r < COUNT_MAX) && (cnt_rdata < COUNT_MAX);
  end

  // memory port control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_r;
    cnt_wdata = '0;
    cnt_raddr = v_idx;
    occ_we    = 1'b0;
    occ_waddr = clr_r[PW-1:WORD_IDX_W];
    occ_wdata = '0;
    occ_raddr = (in_command == CMD_LOAD) ? v_idx[PW-1:WORD_IDX_W] : tw;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cnt_we = 1'b1;
        occ_we = 1'b1;
      end
      ST_IDLE: ;
      ST_LD: begin
        if (ld_ok) begin
          cnt_we    = 1'b1;
          cnt_waddr = vr_idx;
          cnt_wdata = cnt_rdata + CNT_W'(1);
          occ_we    = 1'b1;
          occ_waddr = vr_idx[PW-1:WORD_IDX_W];
          occ_wdata = word_set;
        end
      end
      ST_RD1: begin
        occ_raddr = w1_r;
        cnt_raddr = pick_c;
      end
      ST_RD2: begin
        cnt_raddr = pick_c;
      end
      ST_CNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = pick_r;
        cnt_wdata = cnt_rdata - CNT_W'(1);
        if (cnt_rdata == CNT_W'(1)) begin
          occ_we    = 1'b1;
          occ_waddr = pick_r[PW-1:WORD_IDX_W];
          occ_wdata = word_clr;
        end
        div_start = 1'b1;
      end
      ST_DIV: ;
      ST_OUT: ;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            state_nxt = ST_LD;
          end else if (v_ext >= m_eff || total_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RD1;
          end
        end
      end
      ST_LD:   state_nxt = ST_IDLE;
      ST_RD1:  state_nxt = (summ_r[t_r[PW-1:WORD_IDX_W]] && masked != '0) ? ST_CNT : ST_RD2;
      ST_RD2:  state_nxt = ST_CNT;
      ST_CNT:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      modulus_r   <= MOD_W'(1024);
      total_r     <= '0;
      summ_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) modulus_r <= cfg_wdata;
      if (state_r == ST_CLR) clr_r <= clr_r + PW'(1);

      // load the output register when it is free or being taken, else drop it once taken
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_sum_r   <= res_sum_r;
        out_stat_r  <= res_stat_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLR: ;
        ST_IDLE: begin
          if (accept) begin
            v_r  <= v_ext;
            m_r  <= m_eff;
            t_r  <= t_idx;
            w1_r <= w1_c;
            res_sum_r <= '0;
            res_stat_r <= (v_ext >= m_eff) ? STAT_RANGE : STAT_EMPTY;
          end
        end
        ST_LD: begin
          if (ld_ok) begin
            total_r <= total_r + CNT_W'(1);
            summ_r[vr_idx[PW-1:WORD_IDX_W]] <= 1'b1;
          end
        end
        ST_RD1: begin
          pick_r <= pick_c;
          word_r <= occ_rdata;
        end
        ST_RD2: begin
          pick_r <= pick_c;
          word_r <= occ_rdata;
        end
        ST_CNT: begin
          total_r <= total_r - CNT_W'(1);
          if (cnt_rdata == CNT_W'(1) && word_clr == '0) begin
            summ_r[pick_r[PW-1:WORD_IDX_W]] <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_sum_r  <= VAL_W'(div_rem);
            res_stat_r <= STAT_OK;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sum_result = out_sum_r;
  assign out_status     = out_stat_r;

  csm_count_mem #(.AW(PW)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  csm_occ_mem #(.AW(WIW)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  csm_mod_unit #(.DW(SW), .RW(CW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (SW'(v_r) + SW'(pick_r)),
    .divisor   (m_r),
    .done      (div_done),
    .remainder (div_rem)
  );

endmodule
`default_nettype wire

// File: sim/circular_successor_multiset_core_tb.sv
// Testbench for circular_successor_multiset_core: directed and random loads and
// queries, predicted by an in-bench multiset model, checked on the result channel.
// Depends on csm_pkg and the core RTL.
`timescale 1ns / 100ps
module circular_successor_multiset_core_tb;
  import csm_pkg::*;

  localparam int MAXV = 1024;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic             cmd;
    logic [VAL_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0]  sum;
    logic [STAT_W-1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_LOAD;
  logic [VAL_W-1:0] in_item_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VAL_W-1:0] out_sum_result;
  logic [STAT_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  circular_successor_multiset_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_item_value(in_item_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sum_result(out_sum_result), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a private copy of the multiset and the modulus.
  logic [MOD_W-1:0] mod_reg;
  logic [CNT_W-1:0] copies[MAXV];
  int unsigned held;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int cycles = 0;
  int answers_seen = 0;
  int queries_sent = 0;
  int send_idle_pct = 0;   // sender gap chance, percent
  int recv_stall_pct = 0;  // receiver stall chance, percent
  int hold_off = 0;        // cycles left in a long receiver hold-off
  bit drained_wait = 1'b0; // sender paused while set

  function automatic int effective_mod();
    int m;
    m = mod_reg;
    if (m == 0) m = 1;
    if (m > MAXV) m = MAXV;
    return m;
  endfunction

  // Apply one request to the multiset copy; queue the answer for queries.
  function automatic void predict_request(request_t r);
    int m, t, pick;
    answer_t a;
    m = effective_mod();
    if (r.cmd == CMD_LOAD) begin
      if (r.val < m && held < COUNT_MAX && copies[r.val] < COUNT_MAX) begin
        copies[r.val]++;
        held++;
      end
      return;
    end
    a = '0;
    if (r.val >= m) a.status = STAT_RANGE;
    else if (held == 0) a.status = STAT_EMPTY;
    else begin
      t = (r.val == 0) ? 0 : m - r.val;
      pick = -1;
      for (int i = t; i < MAXV && pick < 0; i++) if (copies[i] != 0) pick = i;
      for (int i = 0; i < MAXV && pick < 0; i++) if (copies[i] != 0) pick = i;
      copies[pick]--;
      held--;
      a.status = STAT_OK;
      a.sum = VAL_W'((r.val + pick) % m);
    end
    expected_answers = {expected_answers, a};
  endfunction

  // Driver: hold the request until accepted, then advance the queue.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_request(request_t'({in_command, in_item_value}));
        if (in_command == CMD_QUERY) queries_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && !drained_wait &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_command <= pending_requests[0].cmd;
          in_item_value <= pending_requests[0].val;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted answer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          $error("unexpected answer sum=%0d status=%0d", out_sum_result, out_status);
          errors++;
        end else begin
          if (out_sum_result !== expected_answers[0].sum) begin
            $error("sum_result expected %0d got %0d", expected_answers[0].sum,
                   out_sum_result);
            errors++;
          end
          if (out_status !== expected_answers[0].status) begin
            $error("status expected %0d got %0d", expected_answers[0].status,
                   out_status);
            errors++;
          end
          void'(expected_answers.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic request_t mk(logic cmd, int v);
    request_t r;
    r.cmd = cmd;
    r.val = VAL_W'(v);
    return r;
  endfunction

  // Append one request to the driver queue.
  function automatic void queue_request(request_t r);
    pending_requests = {pending_requests, r};
  endfunction

  // Wait until every queued request went out and every answer came back.
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_modulus(int m);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= MOD_W'(m);
    mod_reg = MOD_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random loads and queries in equal measure below the modulus, with a few of either over the full value range.
  task automatic random_batch(int n, int m);
    int lim;
    lim = (m < 1) ? 1 : (m > MAXV ? MAXV : m);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) begin
        queue_request(mk(1'($urandom_range(1)), int'($urandom_range(1023))));
      end else if ($urandom_range(1) != 0) begin
        queue_request(mk(CMD_LOAD, int'($urandom_range(lim - 1))));
      end else begin
        queue_request(mk(CMD_QUERY, int'($urandom_range(lim - 1))));
      end
    end
  endtask

  initial begin
    int mods[6];
    mods = '{1024, 2047, 0, 1, 7, 300};
    mod_reg = MOD_W'(1024);
    foreach (copies[i]) copies[i] = '0;
    held = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, range errors, extremes, wrap, repeated values.
    queue_request(mk(CMD_QUERY, 0));
    queue_request(mk(CMD_LOAD, 1023));
    queue_request(mk(CMD_LOAD, 0));
    queue_request(mk(CMD_LOAD, 0));
    queue_request(mk(CMD_LOAD, 512));
    queue_request(mk(CMD_QUERY, 1));
    queue_request(mk(CMD_QUERY, 1023));
    queue_request(mk(CMD_QUERY, 0));
    queue_request(mk(CMD_QUERY, 600));
    queue_request(mk(CMD_QUERY, 5));
    queue_request(mk(CMD_QUERY, 5));
    queue_request(mk(CMD_LOAD, 341));
    queue_request(mk(CMD_LOAD, 682));
    write_modulus(600);
    // Lowered modulus: value 682 stays stored; out-of-range load and query.
    queue_request(mk(CMD_LOAD, 700));
    queue_request(mk(CMD_QUERY, 700));
    queue_request(mk(CMD_QUERY, 100));
    queue_request(mk(CMD_QUERY, 599));
    queue_request(mk(CMD_QUERY, 0));

    foreach (mods[k]) begin
      write_modulus(mods[k]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = (ph == 1 || ph == 3) ? 68 : 0;
        recv_stall_pct = (ph == 2 || ph == 3) ? 68 : 0;
        if (ph == 3) begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
        random_batch(56, mods[k] == 0 ? 1 : mods[k]);
        drain();
      end
    end

    // Long receiver hold-off while the sender keeps offering requests.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 40; i++) queue_request(mk(CMD_QUERY, i));
    drain();
    write_modulus(1024);
    // Sender pause after all answers are in, then a last random burst.
    drained_wait = 1'b1;
    repeat (50) @(posedge clk);
    drained_wait = 1'b0;
    random_batch(40, 1024);
    drain();

    $display("Covered %0d queries with %0d answers over six modulus settings,",
             queries_sent, answers_seen);
    $display("idle and stall phases and a long receiver hold-off.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
